// ===== rtl/src_pkg.sv =====
// Package for the sensor reading converter: beat payload types, channel codes,
// the internal pipeline token and the fan speed constants. No dependencies.
`default_nettype none

package src_pkg;

    localparam int DIV_W = 18;
    localparam int QUO_W = 24;
    localparam int READING_W = 25;

    localparam logic [22:0] FAN_SCALE = 23'd5400000;
    localparam logic [QUO_W-1:0] FAN_DIVIDEND = QUO_W'(2 * FAN_SCALE);
    localparam logic [15:0] TACH_STALLED = 16'hFFFF;
    localparam logic [15:0] WORD_SIGN_BIT = 16'h8000;

    localparam logic [1:0] FUNC_LOCAL = 2'd0;
    localparam logic [1:0] FUNC_REMOTE = 2'd1;
    localparam logic [1:0] FUNC_FAN = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] high_byte;
        logic [7:0] low_byte;
    } in_t;

    typedef struct packed {
        logic signed [READING_W-1:0] reading;
        logic bad_channel;
    } out_t;

    typedef struct packed {
        logic use_div;
        logic bad;
        logic signed [READING_W-1:0] base;
        logic [DIV_W-1:0] div;
        logic [DIV_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } pipe_t;

endpackage

`default_nettype wire

// ===== rtl/sensor_reading_converter.sv =====
// Top level of the sensor reading converter: decode stage, divider pipeline
// and output register. Depends on src_pkg, src_decode and src_div_stage.
//
// Each input beat on s_ carries a channel selector and two raw register bytes;
// each output beat on m_ carries one signed reading and a bad channel flag.
// Channel 0 gives the local temperature, channel 1 the rounded remote
// temperature, channel 2 the fan speed in rpm, and channel 3 is flagged bad.
// The cfg_ channel writes the pulses per revolution register at any time the
// block is idle; it is always ready.
// The stages are one decode stage, 24 restoring divider stages with one
// quotient bit each, and the output register. One beat enters per cycle unless stalled.
// Reset clears all valid bits and sets pulses per revolution to 3.
// When the receiver stalls, the output beat holds and stages fill from the
// back; s_ready drops only when every stage holds a beat.
`default_nettype none

module sensor_reading_converter
    import src_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_t        s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_t            m_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_data
);

    logic [1:0] ppr_reg;

    logic stg_valid [0:QUO_W];
    logic stg_ready [0:QUO_W];
    pipe_t stg_data [0:QUO_W];

    logic out_valid_reg;
    out_t out_data_reg;
    out_t out_next;
    pipe_t last;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ppr_reg <= 2'd3;
        end else if (cfg_valid && cfg_ready) begin
            ppr_reg <= cfg_data;
        end
    end

    src_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .ppr       (ppr_reg),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_data  (stg_data[0])
    );

    for (genvar i = 0; i < QUO_W; i++) begin : g_div
        src_div_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .dvd_bit   (FAN_DIVIDEND[QUO_W-1-i]),
            .in_valid  (stg_valid[i]),
            .in_ready  (stg_ready[i]),
            .in_data   (stg_data[i]),
            .out_valid (stg_valid[i+1]),
            .out_ready (stg_ready[i+1]),
            .out_data  (stg_data[i+1])
        );
    end

    assign last = stg_data[QUO_W];
    assign stg_ready[QUO_W] = !out_valid_reg || m_ready;

    always_comb begin
        out_next.bad_channel = last.bad;
        out_next.reading = last.use_div ? {1'b0, last.quo} : last.base;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (stg_ready[QUO_W]) begin
            out_valid_reg <= stg_valid[QUO_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_ready[QUO_W] && stg_valid[QUO_W]) begin
            out_data_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data = out_data_reg;

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bad_channel |-> m_data.reading == '0)
        else $error("Bad channel beat carries a nonzero reading.");

    a_reading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.reading <= $signed(READING_W'(2 * 5400000))
                 && m_data.reading >= -$signed(READING_W'(128)))
        else $error("Reading is outside its range.");

    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("Input stalled while the output was not blocked.");

    a_ppr_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg_valid |=> $stable(ppr_reg))
        else $error("Pulses per revolution changed without a write.");

endmodule

`default_nettype wire

// ===== rtl/src_decode.sv =====
// First pipeline stage: decodes the channel, converts temperatures and builds
// the fan divisor. Depends on src_pkg.
`default_nettype none

module src_decode
    import src_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire in_t   in_data,
    input  wire logic [1:0] ppr,
    output logic       out_valid,
    input  wire logic  out_ready,
    output pipe_t      out_data
);

    logic valid_reg;
    pipe_t data_reg;
    pipe_t data_next;

    logic [15:0] word;
    logic neg;
    logic [15:0] mag;
    logic [8:0] deg;
    logic signed [READING_W-1:0] deg_ext;
    logic signed [READING_W-1:0] remote_val;
    logic [1:0] ppr_eff;
    logic [DIV_W-1:0] count_ext;
    logic [DIV_W-1:0] divisor;
    logic count_ok;

    assign word = {in_data.high_byte, in_data.low_byte};
    assign neg = (word & WORD_SIGN_BIT) != 16'd0;
    assign mag = neg ? (16'd0 - word) : word;
    assign deg = {1'b0, mag[15:8]} + {8'd0, mag[7]};
    assign deg_ext = {{(READING_W-9){1'b0}}, deg};
    assign remote_val = neg ? (READING_W'(0) - deg_ext) : deg_ext;
    assign ppr_eff = (ppr == 2'd0) ? 2'd1 : ppr;
    assign count_ext = {{(DIV_W-16){1'b0}}, word};
    assign count_ok = (word != 16'd0) && (word != TACH_STALLED);

    always_comb begin
        case (ppr_eff)
            2'd1: divisor = count_ext;
            2'd2: divisor = count_ext << 1;
            default: divisor = count_ext + (count_ext << 1);
        endcase
    end

    always_comb begin
        data_next.use_div = 1'b0;
        data_next.bad = 1'b0;
        data_next.base = '0;
        data_next.div = divisor;
        data_next.rem = '0;
        data_next.quo = '0;
        case (in_data.func)
            FUNC_LOCAL: begin
                data_next.base = {{(READING_W-8){in_data.low_byte[7]}}, in_data.low_byte};
            end
            FUNC_REMOTE: begin
                data_next.base = remote_val;
            end
            FUNC_FAN: begin
                data_next.use_div = count_ok;
            end
            default: begin
                data_next.bad = 1'b1;
            end
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

`default_nettype wire

// ===== rtl/src_div_stage.sv =====
// One stage of the restoring divider: brings down one dividend bit and
// produces one quotient bit. Depends on src_pkg.
`default_nettype none

module src_div_stage
    import src_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  dvd_bit,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire pipe_t in_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output pipe_t      out_data
);

    logic valid_reg;
    pipe_t data_reg;
    pipe_t data_next;

    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;
    logic ge;

    assign trial = {in_data.rem, dvd_bit};
    assign ge = trial >= {1'b0, in_data.div};
    assign diff = trial - {1'b0, in_data.div};

    always_comb begin
        data_next = in_data;
        data_next.rem = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        data_next.quo = {in_data.quo[QUO_W-2:0], ge};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data = data_reg;

endmodule

`default_nettype wire
